// ===== hw/rtl/cfh_pkg.sv =====
// Shared types, constants and helper functions of the CRC-32 hex ASCII framer.
`timescale 1ns / 1ps
package cfh_pkg;

  localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 32;

  localparam logic [31:0] CRC_INIT_RST   = 32'h0000_0000;
  localparam logic [7:0]  START_CHAR_RST = 8'h3C;
  localparam logic [7:0]  END_CHAR_RST   = 8'h0A;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CRC_INIT   = 2'd0,
    CFG_START_CHAR = 2'd1,
    CFG_END_CHAR   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    STEP_START,
    STEP_HI,
    STEP_LO,
    STEP_CRC,
    STEP_END
  } step_e;

  // One classified payload byte handed from the front to the back.
  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [31:0] crc;
  } job_t;

  // Entry of the reflected CRC-32 lookup table; depends on the index only.
  function automatic logic [31:0] crc_table(input logic [7:0] idx);
    logic [31:0] c;
    c = {24'd0, idx};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] n8;
    n8 = {4'd0, nib};
    return (nib < 4'd10) ? (8'h30 + n8) : (8'h37 + n8);
  endfunction

endpackage

// ===== hw/rtl/crc32_hex_ascii_framer.sv =====
// Top level of the CRC-32 framed hex ASCII encoder.
`timescale 1ns / 1ps
// Takes payload bytes (tlast marks a frame's final byte) and sends ASCII
// characters: the start character before a frame's first byte, two upper-case
// hex digits per byte, and after the last byte the eight hex digits of the
// reflected CRC-32 (least significant byte first) and the end character.
// tlast on the output marks the last character caused by each input byte.
// Output runs at one character per cycle while m_axis_tready is high; a middle
// byte gives two characters, a frame's first byte three, its last byte eleven
// and a single-byte frame twelve; the input side is held only by a two-entry
// queue in front of the sequencer, and a byte's CRC is done in the cycle it is
// accepted. Configuration writes must happen while no transaction is in flight.
module crc32_hex_ascii_framer import cfh_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // [7:0] out_char
  output logic                  m_axis_tlast
);

  logic [31:0] crc_init_q;
  logic [7:0]  start_char_q;
  logic [7:0]  end_char_q;
  logic        push, pop, queue_full, job_valid;
  job_t        push_data, job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_init_q   <= CRC_INIT_RST;
      start_char_q <= START_CHAR_RST;
      end_char_q   <= END_CHAR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CRC_INIT:   crc_init_q   <= cfg_data_i;
        CFG_START_CHAR: start_char_q <= cfg_data_i[7:0];
        CFG_END_CHAR:   end_char_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  cfh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .crc_init_i   (crc_init_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .queue_full_i (queue_full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  cfh_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (queue_full),
    .pop_i       (pop),
    .valid_o     (job_valid),
    .head_o      (job)
  );

  cfh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_char_i (start_char_q),
    .end_char_i   (end_char_q),
    .job_valid_i  (job_valid),
    .job_i        (job),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_char_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule

// ===== hw/rtl/cfh_queue.sv =====
// Two-entry queue of classified bytes between the front and the back.
`timescale 1ns / 1ps
module cfh_queue import cfh_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t head_o
);

  job_t       mem_q [QUEUE_DEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'(QUEUE_DEPTH));
  assign valid_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(QUEUE_DEPTH)) else $error("queue fill count out of range");

endmodule

// ===== hw/rtl/cfh_front.sv =====
// Front part: accepts payload bytes, tracks frames and runs the CRC.
`timescale 1ns / 1ps
module cfh_front import cfh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] crc_init_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_data_i,
  input  logic        in_last_i,
  input  logic        queue_full_i,
  output logic        push_o,
  output job_t        push_data_o
);

  logic        in_frame_q, in_frame_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] crc_base;

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    // A new frame starts from the configured value rather than the running CRC.
    crc_base   = in_frame_q ? crc_q : crc_init_i;
    crc_d      = (crc_base >> 8) ^ crc_table(crc_base[7:0] ^ in_data_i);
    in_frame_d = push_o ? !in_last_i : in_frame_q;
    push_data_o.data  = in_data_i;
    push_data_o.first = !in_frame_q;
    push_data_o.last  = in_last_i;
    push_data_o.crc   = crc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_o) begin
      crc_q <= crc_d;
    end
  end

  a_frame_closes_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_frame_q) |-> $past(push_o && in_last_i))
    else $error("frame closed without a last byte");
  a_frame_opens_on_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_frame_q) |-> $past(push_o && !in_last_i))
    else $error("frame opened without an accepted byte");

endmodule

// ===== hw/rtl/cfh_back.sv =====
// Back part: turns each classified byte into its characters and drives the output register.
`timescale 1ns / 1ps
module cfh_back import cfh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] start_char_i,
  input  logic [7:0] end_char_i,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o
);

  step_e      step_q, step_d, cur_step;
  logic [2:0] crc_cnt_q, crc_cnt_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q;
  logic       out_last_q;
  logic       load;
  logic [7:0] ch;
  logic       fin;
  logic [2:0] nib_idx;

  assign load        = job_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o       = load && fin;
  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  always_comb begin
    // Only the first byte of a frame carries the start character.
    cur_step  = (step_q == STEP_START && !job_i.first) ? STEP_HI : step_q;
    // CRC bytes go least significant first, high nibble of each first.
    nib_idx   = crc_cnt_q ^ 3'd1;
    ch        = 8'h00;
    fin       = 1'b0;
    step_d    = step_q;
    crc_cnt_d = crc_cnt_q;
    unique case (cur_step)
      STEP_START: begin
        ch     = start_char_i;
        step_d = STEP_HI;
      end
      STEP_HI: begin
        ch     = hex_char(job_i.data[7:4]);
        step_d = STEP_LO;
      end
      STEP_LO: begin
        ch     = hex_char(job_i.data[3:0]);
        fin    = !job_i.last;
        step_d = job_i.last ? STEP_CRC : STEP_START;
      end
      STEP_CRC: begin
        ch        = hex_char(job_i.crc[{nib_idx, 2'b00} +: 4]);
        crc_cnt_d = crc_cnt_q + 3'd1;
        step_d    = (crc_cnt_q == 3'd7) ? STEP_END : STEP_CRC;
      end
      STEP_END: begin
        ch     = end_char_i;
        fin    = 1'b1;
        step_d = STEP_START;
      end
      default: begin
        step_d = STEP_START;
      end
    endcase
    out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_START;
      crc_cnt_q   <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (load) begin
        step_q    <= step_d;
        crc_cnt_q <= crc_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_char_q <= ch;
      out_last_q <= fin;
    end
  end

  a_crc_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_i && (step_q == STEP_CRC || step_q == STEP_END)) |-> job_i.last)
    else $error("CRC characters for a byte that does not close a frame");
  a_cnt_idle_outside_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != STEP_CRC) |-> (crc_cnt_q == 3'd0))
    else $error("CRC digit counter not cleared");
  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (out_valid_q && out_last_q))
    else $error("byte retired without a last character");

endmodule
